[src/plain_scalar_type_resolver_core_macros.svh]
// assertion macros shared by the resolver rtl
`ifndef PLAIN_SCALAR_TYPE_RESOLVER_CORE_MACROS_SVH
`define PLAIN_SCALAR_TYPE_RESOLVER_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define PSTR_ASSERT_NOW(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error("pstr check failed");

// next-cycle implication
`define PSTR_ASSERT_NEXT(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error("pstr check failed");

`endif

[src/pstr_pkg.sv]
package pstr_pkg;

   typedef enum logic [8:0] {
      NS_START = 9'b000000001,
      NS_SIGN  = 9'b000000010,
      NS_INT   = 9'b000000100,
      NS_DOT   = 9'b000001000,
      NS_FRAC  = 9'b000010000,
      NS_E     = 9'b000100000,
      NS_ESIGN = 9'b001000000,
      NS_EXP   = 9'b010000000,
      NS_DEAD  = 9'b100000000
   } shape_type;

   localparam logic [1:0] RADIX_UNDEC = 2'd0;
   localparam logic [1:0] RADIX_DEC   = 2'd1;
   localparam logic [1:0] RADIX_HEX   = 2'd2;
   localparam logic [1:0] RADIX_OCT   = 2'd3;

   localparam logic [2:0] KIND_NULL     = 3'd0;
   localparam logic [2:0] KIND_BOOL     = 3'd1;
   localparam logic [2:0] KIND_INT      = 3'd2;
   localparam logic [2:0] KIND_FLOAT    = 3'd3;
   localparam logic [2:0] KIND_OVERFLOW = 3'd4;
   localparam logic [2:0] KIND_STRING   = 3'd5;

   localparam logic [1:0] FS_ORDINARY = 2'd0;
   localparam logic [1:0] FS_PLUS_INF = 2'd1;
   localparam logic [1:0] FS_MINUS_INF = 2'd2;
   localparam logic [1:0] FS_NAN      = 2'd3;

   localparam logic [63:0] LIMIT_MAG = 64'h8000_0000_0000_0000;

   // keyword groups: null words, true words, false words, inf words, nan words
   localparam int KW_FIRST_BOOL  = 4;
   localparam int KW_FIRST_FALSE = 7;
   localparam int KW_FIRST_INF   = 10;
   localparam int KW_FIRST_NAN   = 13;

   localparam logic [7:0] KW_TEXT [16][8] = '{
      '{"~", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"n", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"N", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"N", "U", "L", "L", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"T", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"T", "R", "U", "E", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
      '{"F", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
      '{"F", "A", "L", "S", "E", 8'h00, 8'h00, 8'h00},
      '{".", "i", "n", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{".", "I", "n", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{".", "I", "N", "F", 8'h00, 8'h00, 8'h00, 8'h00},
      '{".", "n", "a", "n", 8'h00, 8'h00, 8'h00, 8'h00},
      '{".", "N", "a", "N", 8'h00, 8'h00, 8'h00, 8'h00},
      '{".", "N", "A", "N", 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [3:0] KW_LEN [16] = '{
      4'd1, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5,
      4'd5, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4
   };

   typedef struct packed {
      logic [3:0]  pos;
      logic [15:0] alive;
      logic [1:0]  radix;
      shape_type   shape;
      logic        neg;
      logic [63:0] mag;
      logic        ovf;
      logic        flag_sign;
      logic        flag_digit;
      logic        flag_bad;
   } state_type;

   localparam state_type STATE_RESET = '{
      pos: 4'd0, alive: 16'hFFFF, radix: RADIX_UNDEC, shape: NS_START, neg: 1'b0,
      mag: 64'd0, ovf: 1'b0, flag_sign: 1'b0, flag_digit: 1'b0, flag_bad: 1'b0
   };

   // final state of a scalar, pos holds the index of its last byte
   typedef struct packed {
      logic      empty;
      state_type st;
   } snap_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic               bool_value;
      logic signed [63:0] int_value;
      logic [1:0]         float_special;
   } result_type;

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_sgn(input logic [7:0] c);
      return (c == "+") || (c == "-");
   endfunction

   function automatic logic is_exp(input logic [7:0] c);
      return (c == "e") || (c == "E");
   endfunction

endpackage

[src/plain_scalar_type_resolver_core.sv]
// one byte beat accepted per cycle while req_tready is high; a scalar of n bytes takes n beats
// the beat with tlast fills the snapshot register; the result then moves into the output register once it is free
// throughput: one beat per cycle while req_tready is high, set by the combinational per-byte state update
// reset (synchronous, active high) clears the scan state and both valid flags
// after every result the scan state returns to its reset value
`include "plain_scalar_type_resolver_core_macros.svh"

module plain_scalar_type_resolver_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_byte
   input  logic        req_tlast,   // last_byte
   input  logic        req_tuser,   // empty_scalar
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // bool_value, int_value, float_special, zero pad
   output logic [2:0]  rsp_tuser    // kind
);

   pstr_pkg::state_type  work_ff, work_in, step_nxt;
   pstr_pkg::snap_type   snap_ff, snap_in;
   pstr_pkg::result_type out_ff, out_in, cls_res;
   logic                 snap_vld_ff, snap_vld_in;
   logic                 out_vld_ff, out_vld_in;
   logic                 beat, finish, out_free, snap_adv;

   pstr_step u_step (
      .cur       (work_ff),
      .char_byte (req_tdata),
      .nxt       (step_nxt)
   );

   pstr_classify u_classify (
      .snap (snap_ff),
      .res  (cls_res)
   );

   assign out_free   = !out_vld_ff || rsp_tready;
   assign snap_adv   = snap_vld_ff && out_free;
   assign req_tready = !snap_vld_ff || out_free;
   assign beat       = req_tvalid && req_tready;
   assign finish     = beat && req_tlast;

   always_comb begin
      work_in = work_ff;
      if (finish) work_in = pstr_pkg::STATE_RESET;
      else if (beat && !req_tuser) work_in = step_nxt;

      snap_in        = snap_ff;
      snap_in.empty  = req_tuser;
      snap_in.st     = step_nxt;
      snap_in.st.pos = work_ff.pos;
      if (!finish) snap_in = snap_ff;

      snap_vld_in = snap_vld_ff;
      if (finish) snap_vld_in = 1'b1;
      else if (snap_adv) snap_vld_in = 1'b0;

      out_in     = snap_adv ? cls_res : out_ff;
      out_vld_in = out_vld_ff;
      if (snap_adv) out_vld_in = 1'b1;
      else if (rsp_tready) out_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff     <= pstr_pkg::STATE_RESET;
         snap_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         work_ff     <= work_in;
         snap_vld_ff <= snap_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {5'b00000, out_ff.float_special, out_ff.int_value, out_ff.bool_value};

   `PSTR_ASSERT_NOW(a_int_only_for_int, out_vld_ff && out_ff.kind != pstr_pkg::KIND_INT, out_ff.int_value == 64'd0)
   `PSTR_ASSERT_NOW(a_special_only_float, out_vld_ff && out_ff.kind != pstr_pkg::KIND_FLOAT, out_ff.float_special == pstr_pkg::FS_ORDINARY)
   `PSTR_ASSERT_NEXT(a_work_cleared, finish, work_ff == pstr_pkg::STATE_RESET)
   `PSTR_ASSERT_NEXT(a_snap_moves_out, snap_adv, out_vld_ff)
   `PSTR_ASSERT_NOW(a_hold_when_full, snap_vld_ff && !out_free, !req_tready)

endmodule

[src/pstr_step.sv]
module pstr_step (
   input  pstr_pkg::state_type cur,
   input  logic [7:0]          char_byte,
   output pstr_pkg::state_type nxt
);

   logic [3:0]  idx;
   logic        off;
   logic [3:0]  kpos;
   logic        dec;
   logic        sgn;
   logic        zero_first;
   logic [1:0]  radix_new;
   logic        rdig_ok;
   logic [3:0]  rdig;
   logic        push_en;
   logic [1:0]  push_radix;
   logic [3:0]  push_dig;
   logic [67:0] prod;
   pstr_pkg::shape_type ns;

   always_comb begin
      nxt        = cur;
      idx        = cur.pos;
      dec        = pstr_pkg::is_dec(char_byte);
      sgn        = pstr_pkg::is_sgn(char_byte);
      off        = 1'b0;
      kpos       = 4'd0;

      // keyword matching
      for (int w = 0; w < 16; w++) begin
         if (cur.alive[w]) begin
            if (w >= pstr_pkg::KW_FIRST_INF && idx == 4'd0 && sgn) begin
               if (char_byte == "-" && w >= pstr_pkg::KW_FIRST_NAN) nxt.alive[w] = 1'b0;
            end else begin
               off  = (w >= pstr_pkg::KW_FIRST_INF) && cur.flag_sign;
               kpos = idx - {3'b000, off};
               if (!(kpos < pstr_pkg::KW_LEN[w]) ||
                   pstr_pkg::KW_TEXT[w][kpos[2:0]] != char_byte) begin
                  nxt.alive[w] = 1'b0;
               end
            end
         end
      end

      // radix decision on the second byte
      zero_first = (cur.shape == pstr_pkg::NS_INT) && !cur.flag_sign && (cur.mag == 64'd0);
      radix_new  = cur.radix;
      if (idx == 4'd1) begin
         if (zero_first && char_byte == "x") radix_new = pstr_pkg::RADIX_HEX;
         else if (zero_first && char_byte == "o") radix_new = pstr_pkg::RADIX_OCT;
         else radix_new = pstr_pkg::RADIX_DEC;
      end
      nxt.radix = radix_new;

      // digit of a prefixed radix
      rdig_ok = 1'b1;
      rdig    = 4'd0;
      if (dec) rdig = char_byte[3:0];
      else if ((char_byte >= "a" && char_byte <= "f") || (char_byte >= "A" && char_byte <= "F"))
         rdig = char_byte[3:0] + 4'd9;
      else rdig_ok = 1'b0;
      if (radix_new == pstr_pkg::RADIX_OCT && rdig[3]) rdig_ok = 1'b0;

      // next number shape
      case (cur.shape)
         pstr_pkg::NS_START:
            ns = sgn ? pstr_pkg::NS_SIGN : dec ? pstr_pkg::NS_INT :
                 (char_byte == ".") ? pstr_pkg::NS_DOT : pstr_pkg::NS_DEAD;
         pstr_pkg::NS_SIGN:
            ns = dec ? pstr_pkg::NS_INT : (char_byte == ".") ? pstr_pkg::NS_DOT :
                 pstr_pkg::NS_DEAD;
         pstr_pkg::NS_INT:
            ns = dec ? pstr_pkg::NS_INT : (char_byte == ".") ? pstr_pkg::NS_DOT :
                 pstr_pkg::is_exp(char_byte) ? pstr_pkg::NS_E : pstr_pkg::NS_DEAD;
         pstr_pkg::NS_DOT:
            ns = dec ? pstr_pkg::NS_FRAC :
                 (pstr_pkg::is_exp(char_byte) && cur.flag_digit) ? pstr_pkg::NS_E :
                 pstr_pkg::NS_DEAD;
         pstr_pkg::NS_FRAC:
            ns = dec ? pstr_pkg::NS_FRAC :
                 pstr_pkg::is_exp(char_byte) ? pstr_pkg::NS_E : pstr_pkg::NS_DEAD;
         pstr_pkg::NS_E:
            ns = sgn ? pstr_pkg::NS_ESIGN : dec ? pstr_pkg::NS_EXP : pstr_pkg::NS_DEAD;
         pstr_pkg::NS_ESIGN:
            ns = dec ? pstr_pkg::NS_EXP : pstr_pkg::NS_DEAD;
         pstr_pkg::NS_EXP:
            ns = dec ? pstr_pkg::NS_EXP : pstr_pkg::NS_DEAD;
         default:
            ns = pstr_pkg::NS_DEAD;
      endcase
      nxt.shape = ns;

      // digit push, at most one per byte
      push_en    = 1'b0;
      push_radix = radix_new;
      push_dig   = rdig;
      if (idx >= 4'd2 && radix_new inside {pstr_pkg::RADIX_HEX, pstr_pkg::RADIX_OCT}) begin
         if (rdig_ok) push_en = 1'b1;
         else nxt.flag_bad = 1'b1;
      end else if (ns == pstr_pkg::NS_INT) begin
         push_en    = 1'b1;
         push_radix = pstr_pkg::RADIX_DEC;
         push_dig   = char_byte[3:0];
      end

      case (push_radix)
         pstr_pkg::RADIX_HEX: prod = {cur.mag, 4'b0000};
         pstr_pkg::RADIX_OCT: prod = {1'b0, cur.mag, 3'b000};
         default:             prod = {1'b0, cur.mag, 3'b000} + {3'b000, cur.mag, 1'b0};
      endcase
      prod = prod + {64'd0, push_dig};

      if (push_en && !cur.ovf) begin
         if (prod > {4'b0000, pstr_pkg::LIMIT_MAG}) nxt.ovf = 1'b1;
         else nxt.mag = prod[63:0];
      end

      if (dec && (cur.shape inside {pstr_pkg::NS_START, pstr_pkg::NS_SIGN, pstr_pkg::NS_INT,
                                    pstr_pkg::NS_DOT, pstr_pkg::NS_FRAC}))
         nxt.flag_digit = 1'b1;

      if (idx == 4'd0 && sgn) begin
         nxt.flag_sign = 1'b1;
         nxt.neg       = (char_byte == "-");
      end

      if (cur.pos != 4'hF) nxt.pos = cur.pos + 4'd1;
   end

endmodule

[src/pstr_classify.sv]
module pstr_classify (
   input  pstr_pkg::snap_type   snap,
   output pstr_pkg::result_type res
);

   logic       hit_any;
   logic [3:0] hit_idx;
   logic       off;
   logic [3:0] idx;

   always_comb begin
      idx     = snap.st.pos;
      hit_any = 1'b0;
      hit_idx = 4'd0;
      off     = 1'b0;
      // lowest matching keyword wins
      for (int w = 15; w >= 0; w--) begin
         off = (w >= pstr_pkg::KW_FIRST_INF) && snap.st.flag_sign;
         if (snap.st.alive[w] && idx == pstr_pkg::KW_LEN[w] + {3'b000, off} - 4'd1) begin
            hit_any = 1'b1;
            hit_idx = 4'(w);
         end
      end

      res.kind          = pstr_pkg::KIND_STRING;
      res.bool_value    = 1'b0;
      res.int_value     = '0;
      res.float_special = pstr_pkg::FS_ORDINARY;

      if (snap.empty) begin
         res.kind = pstr_pkg::KIND_NULL;
      end else if (hit_any) begin
         if (hit_idx < 4'(pstr_pkg::KW_FIRST_BOOL)) begin
            res.kind = pstr_pkg::KIND_NULL;
         end else if (hit_idx < 4'(pstr_pkg::KW_FIRST_INF)) begin
            res.kind       = pstr_pkg::KIND_BOOL;
            res.bool_value = hit_idx < 4'(pstr_pkg::KW_FIRST_FALSE);
         end else if (hit_idx < 4'(pstr_pkg::KW_FIRST_NAN)) begin
            res.kind          = pstr_pkg::KIND_FLOAT;
            res.float_special = snap.st.neg ? pstr_pkg::FS_MINUS_INF : pstr_pkg::FS_PLUS_INF;
         end else begin
            res.kind          = pstr_pkg::KIND_FLOAT;
            res.float_special = pstr_pkg::FS_NAN;
         end
      end else if ((snap.st.radix == pstr_pkg::RADIX_HEX || snap.st.radix == pstr_pkg::RADIX_OCT)
                   && idx >= 4'd2) begin
         if (snap.st.flag_bad) begin
            res.kind = pstr_pkg::KIND_STRING;
         end else if (snap.st.ovf || snap.st.mag[63]) begin
            res.kind = pstr_pkg::KIND_OVERFLOW;
         end else begin
            res.kind      = pstr_pkg::KIND_INT;
            res.int_value = snap.st.mag;
         end
      end else if (snap.st.shape == pstr_pkg::NS_INT) begin
         if (snap.st.ovf) begin
            res.kind = pstr_pkg::KIND_OVERFLOW;
         end else if (snap.st.neg) begin
            res.kind      = pstr_pkg::KIND_INT;
            res.int_value = 64'd0 - snap.st.mag;
         end else if (snap.st.mag[63]) begin
            res.kind = pstr_pkg::KIND_OVERFLOW;
         end else begin
            res.kind      = pstr_pkg::KIND_INT;
            res.int_value = snap.st.mag;
         end
      end else if (snap.st.shape == pstr_pkg::NS_FRAC || snap.st.shape == pstr_pkg::NS_EXP ||
                   (snap.st.shape == pstr_pkg::NS_DOT && snap.st.flag_digit)) begin
         res.kind = pstr_pkg::KIND_FLOAT;
      end
   end

endmodule
